// ===== hw/rtl/mes_pkg.sv =====
// shared types, codes and sizes of the maze explorer step core
`default_nettype none

package mes_pkg;

  // default grid size
  localparam int unsigned GridRowsDef = 16;
  localparam int unsigned GridColsDef = 16;

  // field widths
  localparam int unsigned CoordW    = 4;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 4;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 16;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgStartRow     = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgStartCol     = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgStartHeading = 2'd2;

  // side of the robot, as absolute direction minus heading
  localparam logic [1:0] RelFront = 2'd0;
  localparam logic [1:0] RelRight = 2'd1;
  localparam logic [1:0] RelBack  = 2'd2;
  localparam logic [1:0] RelLeft  = 2'd3;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    ACT_STRAIGHT = 2'd0,
    ACT_LEFT     = 2'd1,
    ACT_RIGHT    = 2'd2,
    ACT_UTURN    = 2'd3
  } action_e;

  typedef struct packed {
    logic right_open;
    logic front_open;
    logic left_open;
  } sense_t;

  typedef struct packed {
    dir_e    pick;
    action_e action;
  } step_t;

  typedef struct packed {
    logic              off_grid;
    dir_e              new_heading;
    logic [CoordW-1:0] new_col;
    logic [CoordW-1:0] new_row;
    action_e           action;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mes_step_pick.sv =====
// direction choice: open and unvisited neighbour by priority, else u-turn
`default_nettype none

module mes_step_pick (
  input  mes_pkg::sense_t sense_i,
  input  mes_pkg::dir_e   heading_i,
  input  logic [3:0]      visited_i,  // one bit per absolute direction, off grid reads 0
  output mes_pkg::step_t  step_o
);
  import mes_pkg::*;

  logic [3:0] open_d;
  logic [3:0] cand;
  dir_e       pick;

  // open flag of each absolute direction from the relative sensors
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      case (2'(d) - 2'(heading_i))
        RelFront: open_d[d] = sense_i.front_open;
        RelRight: open_d[d] = sense_i.right_open;
        RelLeft:  open_d[d] = sense_i.left_open;
        default:  open_d[d] = 1'b0;
      endcase
    end
  end

  assign cand = open_d & ~visited_i;

  always_comb begin
    if (cand[DIR_N]) begin
      pick = DIR_N;
    end else if (cand[DIR_E]) begin
      pick = DIR_E;
    end else if (cand[DIR_S]) begin
      pick = DIR_S;
    end else if (cand[DIR_W]) begin
      pick = DIR_W;
    end else begin
      pick = dir_e'(2'(heading_i) + RelBack);
    end
  end

  always_comb begin
    step_o.pick = pick;
    case (2'(pick) - 2'(heading_i))
      RelFront: step_o.action = ACT_STRAIGHT;
      RelLeft:  step_o.action = ACT_LEFT;
      RelRight: step_o.action = ACT_RIGHT;
      default:  step_o.action = ACT_UTURN;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mes_row_store.sv =====
// row memory of the visited map with per-row valid bits
`default_nettype none

module mes_row_store #(
  parameter  int unsigned Depth = mes_pkg::GridRowsDef,
  parameter  int unsigned Width = mes_pkg::GridColsDef,
  localparam int unsigned AW    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  import mes_pkg::*;

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rd_q;
  logic             rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // a row never written reads as all clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_ok_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_ok_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/maze_explorer_step_core.sv =====
// maze explorer step core: one exploration step per wall sensor reading
//
// input stream s_axis: one transaction per sensor reading (left, front, right open)
// output stream m_axis: one transaction per reading with action, new position,
//   new heading and an off-grid flag
// config port: start row, column and heading, sampled when the first reading after
//   reset is processed; writes after that have no effect until the next reset
// path: a reading sits in the input register, and its step result is registered in the
//   result register that drives m_axis_tvalid and m_axis_tdata
// throughput: one reading per cycle while m_axis_tready is high; the step logic is
//   combinational between input register and result register, and the row memory read that
//   refills the neighbour window lands in time for the next reading
// reset: position, heading and window clear, all row valid bits clear, so the whole
//   visited map reads as unvisited; no clearing pass is needed
// stall: when m_axis_tready is low the result register holds, one more reading
//   waits in the input register, then s_axis_tready drops
`default_nettype none

module maze_explorer_step_core #(
  parameter int unsigned GRID_ROWS = mes_pkg::GridRowsDef,
  parameter int unsigned GRID_COLS = mes_pkg::GridColsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [mes_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [mes_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // sensor readings
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mes_pkg::InTdataW-1:0]     s_axis_tdata,   // left_open, front_open, right_open
  // step results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mes_pkg::OutTdataW-1:0]    m_axis_tdata    // action[2], new_row[4], new_col[4],
                                                           // new_heading[2], off_grid[1]
);
  import mes_pkg::*;

  localparam int unsigned RW = $clog2(GRID_ROWS);
  localparam int unsigned CW = $clog2(GRID_COLS);
  localparam logic [RW-1:0] LastRow = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] LastCol = CW'(GRID_COLS - 1);

  // configuration registers
  logic [CoordW-1:0] start_row_q, start_col_q;
  dir_e              start_hdg_q;

  // pipeline registers
  logic    in_valid_q;
  sense_t  in_sense_q;
  logic    out_valid_q;
  result_t out_q, out_d;
  logic    advance;

  // exploration state: position, heading, and a three-row window of the visited map
  logic            started_q;
  logic [RW-1:0]   row_q, row_d;
  logic [CW-1:0]   col_q, col_d;
  dir_e            hdg_q;
  logic [GRID_COLS-1:0] center_q, center_d;
  logic [GRID_COLS-1:0] above_q, above_d;
  logic [GRID_COLS-1:0] below_q, below_d;
  logic            above_ram_q, below_ram_q;  // that row is still in the memory read register

  // step signals
  logic [RW+3:0]        srow_ext;
  logic [CW+3:0]        scol_ext;
  logic [RW-1:0]        cur_row, start_row_sat;
  logic [CW-1:0]        cur_col, start_col_sat;
  dir_e                 cur_hdg;
  logic [GRID_COLS-1:0] ram_rdata, above_eff, below_eff, center_eff;
  logic [CW-1:0]        col_e, col_w;
  logic                 n_in, s_in, e_in, w_in;
  logic [3:0]           visited;
  step_t                step;
  logic                 step_in, shift_n, shift_s;
  logic                 ram_we, ram_re;
  logic [RW-1:0]        ram_waddr, ram_raddr;
  logic [GRID_COLS-1:0] ram_wdata;
  logic [RW:0]          row_x;
  logic [RW+CoordW-1:0] row_out_ext;
  logic [CW+CoordW-1:0] col_out_ext;

  // ---------------------------------------------------------------- config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_row_q <= '0;
      start_col_q <= '0;
      start_hdg_q <= DIR_N;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgStartRow:     start_row_q <= cfg_wdata_i;
        CfgStartCol:     start_col_q <= cfg_wdata_i;
        CfgStartHeading: start_hdg_q <= dir_e'(cfg_wdata_i[1:0]);
        default:         ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  // the stored reading moves on whenever the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sense_q <= sense_t'(s_axis_tdata[2:0]);
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------- current position
  // start cell saturates to the last row or column of the grid
  assign srow_ext      = {{RW{1'b0}}, start_row_q};
  assign scol_ext      = {{CW{1'b0}}, start_col_q};
  assign start_row_sat = (32'(start_row_q) < GRID_ROWS) ? srow_ext[RW-1:0] : LastRow;
  assign start_col_sat = (32'(start_col_q) < GRID_COLS) ? scol_ext[CW-1:0] : LastCol;

  assign cur_row = started_q ? row_q : start_row_sat;
  assign cur_col = started_q ? col_q : start_col_sat;
  assign cur_hdg = started_q ? hdg_q : start_hdg_q;

  // window rows; before the first step all are clear, the start cell is marked here
  assign above_eff  = above_ram_q ? ram_rdata : above_q;
  assign below_eff  = below_ram_q ? ram_rdata : below_q;
  assign center_eff = started_q ? center_q : (GRID_COLS'(1) << start_col_sat);

  // ---------------------------------------------------------------- neighbour lookup
  assign n_in  = (cur_row != '0);
  assign s_in  = (cur_row != LastRow);
  assign w_in  = (cur_col != '0);
  assign e_in  = (cur_col != LastCol);
  assign col_e = cur_col + CW'(1);
  assign col_w = cur_col - CW'(1);

  // a neighbour off the grid counts as unvisited
  always_comb begin
    visited        = '0;
    visited[DIR_N] = n_in && above_eff[cur_col];
    visited[DIR_S] = s_in && below_eff[cur_col];
    visited[DIR_E] = e_in && center_eff[col_e];
    visited[DIR_W] = w_in && center_eff[col_w];
  end

  mes_step_pick u_pick (
    .sense_i   (in_sense_q),
    .heading_i (cur_hdg),
    .visited_i (visited),
    .step_o    (step)
  );

  // ---------------------------------------------------------------- move
  always_comb begin
    case (step.pick)
      DIR_N:   step_in = n_in;
      DIR_E:   step_in = e_in;
      DIR_S:   step_in = s_in;
      default: step_in = w_in;
    endcase
  end

  assign shift_n = (step.pick == DIR_N) && n_in;
  assign shift_s = (step.pick == DIR_S) && s_in;

  always_comb begin
    row_d = cur_row;
    col_d = cur_col;
    if (step_in) begin
      case (step.pick)
        DIR_N:   row_d = cur_row - RW'(1);
        DIR_S:   row_d = cur_row + RW'(1);
        DIR_E:   col_d = col_e;
        default: col_d = col_w;
      endcase
    end
  end

  // window slides one row on a north or south move; the new cell is marked
  always_comb begin
    if (shift_n) begin
      center_d = above_eff;
    end else if (shift_s) begin
      center_d = below_eff;
    end else begin
      center_d = center_eff;
    end
    center_d = center_d | (GRID_COLS'(1) << col_d);
    above_d  = shift_s ? center_eff : above_eff;
    below_d  = shift_n ? center_eff : below_eff;
  end

  // row leaving the window goes back to memory, the row entering is fetched
  assign row_x     = {1'b0, cur_row};
  assign ram_we    = advance && ((shift_n && s_in) || (shift_s && n_in));
  assign ram_waddr = shift_n ? (cur_row + RW'(1)) : (cur_row - RW'(1));
  assign ram_wdata = shift_n ? below_eff : above_eff;
  assign ram_re    = advance && ((shift_n && (row_x >= (RW + 1)'(2))) ||
                                 (shift_s && ((row_x + (RW + 1)'(2)) < (RW + 1)'(GRID_ROWS))));
  assign ram_raddr = shift_n ? (cur_row - RW'(2)) : (cur_row + RW'(2));

  mes_row_store #(
    .Depth (GRID_ROWS),
    .Width (GRID_COLS)
  ) u_rows (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      hdg_q       <= DIR_N;
      center_q    <= '0;
      above_q     <= '0;
      below_q     <= '0;
      above_ram_q <= 1'b0;
      below_ram_q <= 1'b0;
    end else if (advance) begin
      started_q   <= 1'b1;
      row_q       <= row_d;
      col_q       <= col_d;
      hdg_q       <= step.pick;
      center_q    <= center_d;
      above_q     <= above_d;
      below_q     <= below_d;
      above_ram_q <= shift_n;
      below_ram_q <= shift_s;
    end
  end

  // ---------------------------------------------------------------- result
  assign row_out_ext = {{CoordW{1'b0}}, row_d};
  assign col_out_ext = {{CoordW{1'b0}}, col_d};

  always_comb begin
    out_d.action      = step.action;
    out_d.new_row     = row_out_ext[CoordW-1:0];
    out_d.new_col     = col_out_ext[CoordW-1:0];
    out_d.new_heading = step.pick;
    out_d.off_grid    = !step_in;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - $bits(result_t)){1'b0}}, out_q};

  // ---------------------------------------------------------------- checks
  // the row fetched and the row written back are never the same row
  a_ram_ports_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("row store read and write hit the same row");

  // only one window row can be waiting in the memory read register
  a_one_pending_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(above_ram_q && below_ram_q))
    else $error("both window rows marked as pending from memory");

  // once started the core stays started until reset
  a_started_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

  // the held position never leaves the grid
  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> ((row_q <= LastRow) && (col_q <= LastCol)))
    else $error("position outside the grid");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench of the maze explorer step core: streams wall sensor readings and checks every step
`default_nettype none

module tb;
  import mes_pkg::*;

  localparam int GridRows   = GridRowsDef;
  localparam int GridCols   = GridColsDef;
  localparam int QuietLimit = 2000;  // cycles without any transaction before giving up
  localparam int LongHold   = 80;    // receiver hold-off that backs the pipeline up

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i    = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;   // left_open, front_open, right_open
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;         // action[2], new_row[4], new_col[4],
                                              // new_heading[2], off_grid[1]

  // readings waiting for the driver, and steps the core still owes us
  sense_t  readings_q [$];
  result_t pending_moves [$];

  // knobs set by the sequencer
  bit idle_on       = 1'b0;
  bit long_hold_req = 1'b0;

  int src_gap      = 0;
  int hold_cnt     = 0;
  bit hold_taken   = 1'b0;
  int quiet_cycles = 0;
  int mismatches   = 0;

  // shadow of the start registers and of the robot
  logic [CoordW-1:0] start_row_q     = '0;
  logic [CoordW-1:0] start_col_q     = '0;
  dir_e              start_dir_q     = DIR_N;
  bit                explore_started = 1'b0;
  logic [CoordW-1:0] robot_row       = '0;
  logic [CoordW-1:0] robot_col       = '0;
  dir_e              robot_dir       = DIR_N;
  bit                map_seen [GridRows*GridCols];

  maze_explorer_step_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // step predictor
  // ---------------------------------------------------------------------------

  function automatic bit on_grid(int r, int c);
    return r >= 0 && r < GridRows && c >= 0 && c < GridCols;
  endfunction

  // rows grow to the south, columns to the east
  function automatic void neighbour(dir_e d, output int nr, output int nc);
    nr = int'(robot_row);
    nc = int'(robot_col);
    case (d)
      DIR_N: nr = nr - 1;
      DIR_E: nc = nc + 1;
      DIR_S: nr = nr + 1;
      default: nc = nc - 1;
    endcase
  endfunction

  function automatic result_t advance_robot(sense_t s);
    result_t    res;
    dir_e       pick;
    logic [1:0] rel;
    logic       side_open;
    bit         found;
    int         k, nr, nc;
    // first reading after reset loads the start cell, saturated to the grid
    if (!explore_started) begin
      robot_row = (int'(start_row_q) < GridRows) ? start_row_q : CoordW'(GridRows - 1);
      robot_col = (int'(start_col_q) < GridCols) ? start_col_q : CoordW'(GridCols - 1);
      robot_dir = start_dir_q;
      map_seen[int'(robot_row)*GridCols + int'(robot_col)] = 1'b1;
      explore_started = 1'b1;
    end
    // absolute priority north, east, south, west; back side is never sensed
    found = 1'b0;
    pick  = DIR_N;
    for (k = 0; k < 4; k++) begin
      if (!found) begin
        rel = 2'(k) - robot_dir;
        case (rel)
          RelFront: side_open = s.front_open;
          RelRight: side_open = s.right_open;
          RelLeft:  side_open = s.left_open;
          default:  side_open = 1'b0;
        endcase
        neighbour(dir_e'(2'(k)), nr, nc);
        // a cell off the grid counts as not visited
        if (side_open && !(on_grid(nr, nc) && map_seen[nr*GridCols + nc])) begin
          pick  = dir_e'(2'(k));
          found = 1'b1;
        end
      end
    end
    // dead end or everything open already seen: turn around
    if (!found) pick = dir_e'(2'(robot_dir + 2'd2));
    rel = pick - robot_dir;
    case (rel)
      RelFront: res.action = ACT_STRAIGHT;
      RelLeft:  res.action = ACT_LEFT;
      RelRight: res.action = ACT_RIGHT;
      default:  res.action = ACT_UTURN;
    endcase
    robot_dir = pick;
    neighbour(pick, nr, nc);
    res.off_grid = !on_grid(nr, nc);
    // a step off the edge is held in place, heading still turns
    if (!res.off_grid) begin
      robot_row = CoordW'(nr);
      robot_col = CoordW'(nc);
    end
    map_seen[int'(robot_row)*GridCols + int'(robot_col)] = 1'b1;
    res.new_row     = robot_row;
    res.new_col     = robot_col;
    res.new_heading = robot_dir;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers sensor readings, with random gaps while idling is on
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap       <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap != 0) begin
        src_gap       <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && readings_q.size() != 0 && $urandom_range(7) == 0) begin
        // random idle gap, src_gap drawn from 0 to 9
        src_gap       <= $urandom_range(9);
        s_axis_tvalid <= 1'b0;
      end else if (readings_q.size() != 0) begin
        s_axis_tdata  <= InTdataW'(readings_q.pop_front());
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off to fill the core up
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
      hold_taken    <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_cnt      <= LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(7) == 0) begin
      hold_cnt      <= $urandom_range(9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result transactions, tracks config writes, predicts steps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t got, want, pred;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (pending_moves.size() == 0) begin
          report_mismatch("unexpected result, action", got.action, -1);
        end else begin
          want = pending_moves.pop_front();
          if (got.action != want.action)
            report_mismatch("action", got.action, want.action);
          if (got.new_row != want.new_row)
            report_mismatch("new_row", got.new_row, want.new_row);
          if (got.new_col != want.new_col)
            report_mismatch("new_col", got.new_col, want.new_col);
          if (got.new_heading != want.new_heading)
            report_mismatch("new_heading", got.new_heading, want.new_heading);
          if (got.off_grid != want.off_grid)
            report_mismatch("off_grid", got.off_grid, want.off_grid);
        end
      end
      // registers only matter until the first reading; the predictor ignores them later
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgStartRow:     start_row_q = cfg_wdata_i;
          CfgStartCol:     start_col_q = cfg_wdata_i;
          CfgStartHeading: start_dir_q = dir_e'(cfg_wdata_i[1:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = advance_robot(sense_t'(s_axis_tdata[$bits(sense_t)-1:0]));
        pending_moves = {pending_moves, pred};
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // wait until every reading went in and every step came out, then let the
  // pipeline settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (readings_q.size() != 0 || s_axis_tvalid || pending_moves.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // mostly open sides so the robot roams far; some fully random readings
  task automatic push_random(int count);
    sense_t s;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) begin
        s.left_open  = $urandom_range(3) != 0;
        s.front_open = $urandom_range(3) != 0;
        s.right_open = $urandom_range(3) != 0;
      end else begin
        s = sense_t'($urandom_range(7));
      end
      readings_q = {readings_q, s};
    end
  endtask

  initial begin : sequencer
    logic [2:0] directed_seq [21];
    // every sensor combination, then open runs, dead ends and a step into a seen cell
    directed_seq = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
                     3'd7, 3'd7, 3'd7, 3'd2, 3'd2, 3'd0, 3'd2, 3'd5,
                     3'd7, 3'd0, 3'd1, 3'd4, 3'd6};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values first, then a random corner; the last write before the
    // first reading is the one that counts
    write_reg(CfgStartRow, '0);
    write_reg(CfgStartCol, '0);
    write_reg(CfgStartHeading, '0);
    write_reg(CfgStartRow, $urandom_range(1) ? 4'd15 : 4'd0);
    write_reg(CfgStartCol, $urandom_range(1) ? 4'd15 : 4'd0);
    write_reg(CfgStartHeading, CfgDataW'($urandom_range(3)));

    @(negedge clk_i);
    idle_on = 1'b1;
    foreach (directed_seq[i]) readings_q = {readings_q, sense_t'(directed_seq[i])};
    wait_drained();

    // writes after the start must not move the robot
    write_reg(CfgStartRow, 4'd15);
    write_reg(CfgStartCol, 4'd15);
    write_reg(CfgStartHeading, CfgDataW'(DIR_W));
    @(negedge clk_i);
    push_random(1300);
    long_hold_req = 1'b1;
    wait_drained();

    write_reg(CfgStartRow, 4'd0);
    write_reg(CfgStartCol, 4'd7);
    write_reg(CfgStartHeading, CfgDataW'(DIR_S));
    @(negedge clk_i);
    idle_on = 1'b0;
    push_random(630);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_moves.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
